>>> sv/assert_macros.svh
// Assertion macros shared by the camera pose RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FCPU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define FCPU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/fcpu_pkg.sv
// Shared types, constants and helper functions of the camera pose unit.
`default_nettype none
package fcpu_pkg;

    localparam int POS_W    = 32;
    localparam int ANG_W    = 20;
    localparam int CDC_W    = 36;
    localparam int CDC_ITER = 16;

    localparam logic signed [23:0] HALF_PI_Q16 = 24'sd102944;
    localparam logic signed [23:0] PI_Q16      = 24'sd205887;
    localparam logic signed [23:0] TWO_PI_Q16  = 24'sd411775;

    localparam logic signed [CDC_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CDC_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [CDC_W-1:0] GAIN_Q30    = 36'sd652032874;

    typedef enum logic [2:0] {
        CMD_MOVE         = 3'd0,
        CMD_LOOK_AT      = 3'd1,
        CMD_ADVANCE      = 3'd2,
        CMD_STRAFE_RIGHT = 3'd3,
        CMD_STRAFE_LEFT  = 3'd4,
        CMD_MOVE_UP      = 3'd5,
        CMD_TURN         = 3'd6,
        CMD_NOP          = 3'd7
    } cmd_t;

    // Request from the sequencer to the CORDIC unit.
    typedef struct packed {
        logic start;
        logic vect;
    } cdc_cmd_t;

    // Arctangent of 2^-i in Q30.
    function automatic logic signed [CDC_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [CDC_W-1:0] r;
        case (i)
            5'd0:  r = 36'sd843314857;
            5'd1:  r = 36'sd497837829;
            5'd2:  r = 36'sd263043837;
            5'd3:  r = 36'sd133525159;
            5'd4:  r = 36'sd67021687;
            5'd5:  r = 36'sd33543516;
            5'd6:  r = 36'sd16775851;
            5'd7:  r = 36'sd8388437;
            5'd8:  r = 36'sd4194283;
            5'd9:  r = 36'sd2097149;
            5'd10: r = 36'sd1048576;
            5'd11: r = 36'sd524288;
            5'd12: r = 36'sd262144;
            5'd13: r = 36'sd131072;
            5'd14: r = 36'sd65536;
            5'd15: r = 36'sd32768;
            5'd16: r = 36'sd16384;
            5'd17: r = 36'sd8192;
            5'd18: r = 36'sd4096;
            5'd19: r = 36'sd2048;
            5'd20: r = 36'sd1024;
            5'd21: r = 36'sd512;
            5'd22: r = 36'sd256;
            5'd23: r = 36'sd128;
            5'd24: r = 36'sd64;
            5'd25: r = 36'sd32;
            5'd26: r = 36'sd16;
            5'd27: r = 36'sd8;
            5'd28: r = 36'sd4;
            5'd29: r = 36'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Clamp a wide sum to the signed position range.
    function automatic logic signed [POS_W-1:0] sat_val(input logic signed [37:0] v);
        logic signed [37:0] hi;
        logic signed [37:0] lo;
        hi = 38'sd2147483647;
        lo = -38'sd2147483648;
        if (v > hi) begin
            return hi[POS_W-1:0];
        end else if (v < lo) begin
            return lo[POS_W-1:0];
        end
        return v[POS_W-1:0];
    endfunction

    function automatic logic sat_hit(input logic signed [37:0] v);
        return (v > 38'sd2147483647) || (v < -38'sd2147483648);
    endfunction

    // Clamp a Q7.16 pitch to plus or minus pi/2.
    function automatic logic signed [ANG_W-1:0] clamp_pitch(input logic signed [23:0] v);
        if (v > HALF_PI_Q16) begin
            return HALF_PI_Q16[ANG_W-1:0];
        end else if (v < -HALF_PI_Q16) begin
            return 20'(-HALF_PI_Q16);
        end
        return v[ANG_W-1:0];
    endfunction

    // Round a Q30 angle to Q7.16.
    function automatic logic signed [23:0] q30_to_q16(input logic signed [CDC_W-1:0] z);
        logic signed [CDC_W-1:0] t;
        t = z + 36'sd8192;
        return {{2{t[CDC_W-1]}}, t[CDC_W-1:14]};
    endfunction

endpackage
`default_nettype wire

>>> sv/fcpu_cordic.sv
// Iterative CORDIC unit, rotation and vectoring, one step per cycle.
`default_nettype none
module fcpu_cordic import fcpu_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire cdc_cmd_t                cmd,
    input  wire logic signed [CDC_W-1:0] x_in,
    input  wire logic signed [CDC_W-1:0] y_in,
    input  wire logic signed [CDC_W-1:0] z_in,
    output logic                         done,
    output logic signed [CDC_W-1:0]     x_out,
    output logic signed [CDC_W-1:0]     y_out,
    output logic signed [CDC_W-1:0]     z_out
);

    typedef enum logic {C_IDLE, C_RUN} cstate_t;

    cstate_t                 state_reg;
    logic signed [CDC_W-1:0] x_reg, y_reg, z_reg;
    logic                    flip_reg, vect_reg, done_reg;
    logic [4:0]              step_reg;

    logic signed [CDC_W-1:0] xs, ys, at;
    logic                    sigma;

    // One micro-rotation
    always_comb begin
        xs    = x_reg >>> step_reg;
        ys    = y_reg >>> step_reg;
        at    = atan_q30(step_reg);
        sigma = vect_reg ? (y_reg <= 0) : (z_reg >= 0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE: begin
                    if (cmd.start) begin
                        vect_reg  <= cmd.vect;
                        flip_reg  <= 1'b0;
                        step_reg  <= '0;
                        state_reg <= C_RUN;
                        if (cmd.vect) begin
                            // Pre-rotate left half plane by a quarter turn
                            if (x_in < 0 && y_in >= 0) begin
                                x_reg <= y_in;
                                y_reg <= -x_in;
                                z_reg <= HALF_PI_Q30;
                            end else if (x_in < 0) begin
                                x_reg <= -y_in;
                                y_reg <= x_in;
                                z_reg <= -HALF_PI_Q30;
                            end else begin
                                x_reg <= x_in;
                                y_reg <= y_in;
                                z_reg <= '0;
                            end
                        end else begin
                            x_reg <= x_in;
                            y_reg <= y_in;
                            // Fold angle into plus or minus pi/2
                            if (z_in > HALF_PI_Q30) begin
                                z_reg    <= z_in - PI_Q30;
                                flip_reg <= 1'b1;
                            end else if (z_in < -HALF_PI_Q30) begin
                                z_reg    <= z_in + PI_Q30;
                                flip_reg <= 1'b1;
                            end else begin
                                z_reg <= z_in;
                            end
                        end
                    end
                end
                C_RUN: begin
                    if (sigma) begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - at;
                    end else begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + at;
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(CDC_ITER - 1)) begin
                        state_reg <= C_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign x_out = flip_reg ? -x_reg : x_reg;
    assign y_out = flip_reg ? -y_reg : y_reg;
    assign z_out = z_reg;

endmodule
`default_nettype wire

>>> sv/fcpu_mul.sv
// Registered signed multiplier shared by the pose sequencer.
`default_nettype none
module fcpu_mul import fcpu_pkg::*; (
    input  wire logic               aclk,
    input  wire logic signed [33:0] a,
    input  wire logic signed [31:0] b,
    output logic signed [65:0]      p
);

    logic signed [65:0] p_reg;

    // Register the product
    always_ff @(posedge aclk) begin
        p_reg <= 66'(a) * 66'(b);
    end

    assign p = p_reg;

endmodule
`default_nettype wire

>>> sv/fly_camera_pose_update_top.sv
// Top level of the camera pose unit: command sequencer and pose state.
//
// Input channel s_*: one command word per handshake. s_tuser carries the
// command code; s_tdata carries vectors, amount and turn increments.
// Output channel m_*: one pose word per command, with the saturation flag
// in m_tuser.
// Work per command: unknown codes go straight to the output; move and move up
// take one add; turn adds and then reduces yaw in up to two wrap steps; strafe
// and advance take one or two 16-step passes of the shared CORDIC plus one
// multiply per axis; look-at runs the normalize shift loop (one bit a cycle, up
// to 29 bits) and two CORDIC vectoring passes. A zero look-at vector skips both.
// One command is worked at a time; s_tready is high only while idle, so the
// next command is taken at the earliest in the cycle after the result is loaded.
// A finished pose sits in the output register; the next command is taken
// while it waits, and a second result waits until m_tready takes the first.
// Reset clears position and angles to zero and empties the output register.
`default_nettype none
`include "assert_macros.svh"
module fly_camera_pose_update_top import fcpu_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // vec_x[31:0], vec_y[63:32], vec_z[95:64], amount[127:96],
    // turn_yaw[147:128], turn_pitch[167:148]
    input  wire logic [167:0] s_tdata,
    // command[2:0]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_yaw[114:96],
    // out_pitch[132:115], zero fill[135:133]
    output logic [135:0]      m_tdata,
    // saturated[0]
    output logic              m_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ADD, ST_TURN, ST_SC_YAW, ST_SC_PITCH, ST_MUL, ST_ACC,
        ST_LA_DIFF, ST_LA_NORM, ST_LA_YAW, ST_LA_GMUL, ST_LA_GACC,
        ST_LA_PITCH, ST_WRAP, ST_OUT
    } state_t;

    state_t state_reg;

    logic [2:0]               cmd_reg;
    logic signed [31:0]       vx_reg, vy_reg, vz_reg;
    logic signed [33:0]       amt_reg;
    logic signed [ANG_W-1:0]  ty_reg, tp_reg;

    logic signed [POS_W-1:0]  pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [ANG_W-1:0]  yaw_reg, pitch_reg;

    logic signed [31:0]       s_yaw_reg, c_yaw_reg, s_pitch_reg;
    logic signed [CDC_W-1:0]  lx_reg, ly_reg, lz_reg, ya_reg, mag_reg;
    logic signed [23:0]       wrap_reg;
    logic                     sat_reg;
    logic [1:0]               term_reg;

    cdc_cmd_t                 cdc_cmd_reg;
    logic signed [CDC_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic                     cdc_done;
    logic signed [CDC_W-1:0]  cdc_x, cdc_y, cdc_z;

    logic signed [33:0]       mul_a_reg;
    logic signed [31:0]       mul_b_reg;
    logic signed [65:0]       mul_p;

    logic                     m_tvalid_reg, m_sat_reg;
    logic signed [POS_W-1:0]  m_x_reg, m_y_reg, m_z_reg;
    logic signed [ANG_W-1:0]  m_yaw_reg, m_pitch_reg;

    logic                     s_fire;
    logic signed [33:0]       s_amt;

    logic [1:0]               next_term;
    logic signed [31:0]       next_b;
    logic signed [65:0]       prod_rnd;
    logic signed [37:0]       rnd38, acc_base, acc_sum;
    logic                     last_term;

    logic signed [37:0]       add_x, add_y, add_z;
    logic signed [CDC_W-1:0]  dx, dy, dz, ax, ay, az, mag;
    logic signed [65:0]       gain_rnd;
    logic signed [CDC_W-1:0]  cyaw;

    fcpu_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cdc_cmd_reg),
        .x_in    (cx_reg),
        .y_in    (cy_reg),
        .z_in    (cz_reg),
        .done    (cdc_done),
        .x_out   (cdc_x),
        .y_out   (cdc_y),
        .z_out   (cdc_z)
    );

    fcpu_mul u_mul (
        .aclk (aclk),
        .a    (mul_a_reg),
        .b    (mul_b_reg),
        .p    (mul_p)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign s_amt    = (s_tuser == CMD_STRAFE_LEFT) ? -34'(signed'(s_tdata[127:96]))
                                                   : 34'(signed'(s_tdata[127:96]));
    assign cyaw     = {{2{yaw_reg[ANG_W-1]}}, yaw_reg, 14'b0};

    // Pick the sine or cosine for each product term
    always_comb begin
        next_term = (state_reg == ST_ACC) ? (term_reg + 2'd1) : 2'd0;
        next_b    = c_yaw_reg;
        if (cmd_reg == CMD_ADVANCE) begin
            case (next_term)
                2'd0:    next_b = s_yaw_reg;
                2'd1:    next_b = c_yaw_reg;
                default: next_b = s_pitch_reg;
            endcase
        end else begin
            next_b = (next_term == 2'd0) ? c_yaw_reg : s_yaw_reg;
        end
        last_term = (cmd_reg == CMD_ADVANCE) ? (term_reg == 2'd2) : (term_reg == 2'd1);
    end

    // Round the product and add it to, or subtract it from, the addressed axis
    always_comb begin
        prod_rnd = mul_p + (66'sd1 <<< 29);
        rnd38    = 38'(signed'(prod_rnd[65:30]));
        if (cmd_reg == CMD_ADVANCE) begin
            case (term_reg)
                2'd0:    acc_base = 38'(pos_x_reg);
                2'd1:    acc_base = 38'(pos_z_reg);
                default: acc_base = 38'(pos_y_reg);
            endcase
            acc_sum = (term_reg == 2'd0) ? (acc_base + rnd38) : (acc_base - rnd38);
        end else begin
            acc_base = (term_reg == 2'd0) ? 38'(pos_x_reg) : 38'(pos_z_reg);
            acc_sum  = acc_base + rnd38;
        end
        gain_rnd = mul_p + (66'sd1 <<< 29);
    end

    // Plain adds and the look-at view vector with its largest magnitude
    always_comb begin
        add_x = 38'(pos_x_reg) + 38'(vx_reg);
        add_y = (cmd_reg == CMD_MOVE_UP) ? (38'(pos_y_reg) + 38'(amt_reg))
                                         : (38'(pos_y_reg) + 38'(vy_reg));
        add_z = 38'(pos_z_reg) + 38'(vz_reg);
        dx    = 36'(vx_reg) - 36'(pos_x_reg);
        dy    = 36'(vy_reg) - 36'(pos_y_reg);
        dz    = 36'(vz_reg) - 36'(pos_z_reg);
        ax    = (dx < 0) ? -dx : dx;
        ay    = (dy < 0) ? -dy : dy;
        az    = (dz < 0) ? -dz : dz;
        mag   = ax;
        if (ay > mag) begin
            mag = ay;
        end
        if (az > mag) begin
            mag = az;
        end
    end

    // Sequencer, pose state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            pos_z_reg    <= '0;
            yaw_reg      <= '0;
            pitch_reg    <= '0;
            cdc_cmd_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cdc_cmd_reg <= '0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        cmd_reg  <= s_tuser;
                        vx_reg   <= s_tdata[31:0];
                        vy_reg   <= s_tdata[63:32];
                        vz_reg   <= s_tdata[95:64];
                        amt_reg  <= s_amt;
                        ty_reg   <= s_tdata[147:128];
                        tp_reg   <= s_tdata[167:148];
                        sat_reg  <= 1'b0;
                        term_reg <= 2'd0;
                        case (s_tuser)
                            CMD_MOVE, CMD_MOVE_UP: state_reg <= ST_ADD;
                            CMD_TURN:              state_reg <= ST_TURN;
                            CMD_LOOK_AT:           state_reg <= ST_LA_DIFF;
                            CMD_ADVANCE, CMD_STRAFE_RIGHT, CMD_STRAFE_LEFT: begin
                                cdc_cmd_reg <= '{start: 1'b1, vect: 1'b0};
                                cx_reg      <= GAIN_Q30;
                                cy_reg      <= '0;
                                cz_reg      <= cyaw;
                                state_reg   <= ST_SC_YAW;
                            end
                            default:               state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_ADD: begin
                    if (cmd_reg == CMD_MOVE) begin
                        pos_x_reg <= sat_val(add_x);
                        pos_z_reg <= sat_val(add_z);
                    end
                    pos_y_reg <= sat_val(add_y);
                    sat_reg   <= sat_hit(add_y) ||
                                 ((cmd_reg == CMD_MOVE) && (sat_hit(add_x) || sat_hit(add_z)));
                    state_reg <= ST_OUT;
                end
                ST_TURN: begin
                    wrap_reg  <= 24'(yaw_reg) + 24'(ty_reg) + PI_Q16;
                    pitch_reg <= clamp_pitch(24'(pitch_reg) + 24'(tp_reg));
                    state_reg <= ST_WRAP;
                end
                ST_SC_YAW: begin
                    if (cdc_done) begin
                        s_yaw_reg <= cdc_y[31:0];
                        c_yaw_reg <= cdc_x[31:0];
                        if (cmd_reg == CMD_ADVANCE) begin
                            cdc_cmd_reg <= '{start: 1'b1, vect: 1'b0};
                            cx_reg      <= GAIN_Q30;
                            cy_reg      <= '0;
                            cz_reg      <= {{2{pitch_reg[ANG_W-1]}}, pitch_reg, 14'b0};
                            state_reg   <= ST_SC_PITCH;
                        end else begin
                            mul_a_reg <= amt_reg;
                            mul_b_reg <= cdc_x[31:0];
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_SC_PITCH: begin
                    if (cdc_done) begin
                        s_pitch_reg <= cdc_y[31:0];
                        mul_a_reg   <= amt_reg;
                        mul_b_reg   <= s_yaw_reg;
                        state_reg   <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    // Write back the addressed axis
                    if (cmd_reg == CMD_ADVANCE && term_reg == 2'd2) begin
                        pos_y_reg <= sat_val(acc_sum);
                    end else if (term_reg == 2'd0) begin
                        pos_x_reg <= sat_val(acc_sum);
                    end else begin
                        pos_z_reg <= sat_val(acc_sum);
                    end
                    sat_reg <= sat_reg || sat_hit(acc_sum);
                    if (last_term) begin
                        state_reg <= ST_OUT;
                    end else begin
                        term_reg  <= next_term;
                        mul_a_reg <= amt_reg;
                        mul_b_reg <= next_b;
                        state_reg <= ST_MUL;
                    end
                end
                ST_LA_DIFF: begin
                    lx_reg    <= dx;
                    ly_reg    <= dy;
                    lz_reg    <= dz;
                    mag_reg   <= mag;
                    state_reg <= ST_LA_NORM;
                end
                ST_LA_NORM: begin
                    // Shift one bit a cycle until the tracked magnitude lies in [2^29, 2^30)
                    if (mag_reg == '0) begin
                        state_reg <= ST_OUT;
                    end else if (mag_reg >= (36'sd1 <<< 30)) begin
                        lx_reg  <= lx_reg >>> 1;
                        ly_reg  <= ly_reg >>> 1;
                        lz_reg  <= lz_reg >>> 1;
                        mag_reg <= mag_reg >>> 1;
                    end else if (mag_reg < (36'sd1 <<< 29)) begin
                        lx_reg  <= lx_reg <<< 1;
                        ly_reg  <= ly_reg <<< 1;
                        lz_reg  <= lz_reg <<< 1;
                        mag_reg <= mag_reg <<< 1;
                    end else begin
                        cdc_cmd_reg <= '{start: 1'b1, vect: 1'b1};
                        cx_reg      <= lz_reg;
                        cy_reg      <= lx_reg;
                        cz_reg      <= '0;
                        state_reg   <= ST_LA_YAW;
                    end
                end
                ST_LA_YAW: begin
                    if (cdc_done) begin
                        ya_reg    <= cdc_z;
                        mul_a_reg <= cdc_x[33:0];
                        mul_b_reg <= GAIN_Q30[31:0];
                        state_reg <= ST_LA_GMUL;
                    end
                end
                ST_LA_GMUL: begin
                    state_reg <= ST_LA_GACC;
                end
                ST_LA_GACC: begin
                    cdc_cmd_reg <= '{start: 1'b1, vect: 1'b1};
                    cx_reg      <= gain_rnd[65:30];
                    cy_reg      <= ly_reg;
                    cz_reg      <= '0;
                    state_reg   <= ST_LA_PITCH;
                end
                ST_LA_PITCH: begin
                    if (cdc_done) begin
                        wrap_reg  <= q30_to_q16(ya_reg) + PI_Q16;
                        pitch_reg <= clamp_pitch(q30_to_q16(cdc_z));
                        state_reg <= ST_WRAP;
                    end
                end
                ST_WRAP: begin
                    // Reduce yaw modulo two pi, one add or subtract a cycle
                    if (wrap_reg < 0) begin
                        wrap_reg <= wrap_reg + TWO_PI_Q16;
                    end else if (wrap_reg >= TWO_PI_Q16) begin
                        wrap_reg <= wrap_reg - TWO_PI_Q16;
                    end else begin
                        yaw_reg   <= 20'(wrap_reg - PI_Q16);
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_x_reg      <= pos_x_reg;
                        m_y_reg      <= pos_y_reg;
                        m_z_reg      <= pos_z_reg;
                        m_yaw_reg    <= yaw_reg;
                        m_pitch_reg  <= pitch_reg;
                        m_sat_reg    <= sat_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_sat_reg;
    assign m_tdata  = {3'b000, m_pitch_reg[17:0], m_yaw_reg[18:0],
                       m_z_reg, m_y_reg, m_x_reg};

    `FCPU_ASSERT(a_pitch_range, aclk, aresetn, (pitch_reg <= 20'(HALF_PI_Q16)) && (pitch_reg >= 20'(-HALF_PI_Q16)), "pitch left its clamp range")
    `FCPU_ASSERT(a_yaw_range, aclk, aresetn, (yaw_reg <= 20'(PI_Q16)) && (yaw_reg >= 20'(-PI_Q16)), "yaw left its wrap range")
    `FCPU_ASSERT(a_cdc_done_wait, aclk, aresetn, cdc_done |-> (state_reg == ST_SC_YAW || state_reg == ST_SC_PITCH || state_reg == ST_LA_YAW || state_reg == ST_LA_PITCH), "CORDIC finished with no pass waiting")

endmodule
`default_nettype wire
